FILE: src/lavm_pkg.sv
// lavm_pkg: widths, constants, row codes, matrix types and fixed-point helpers
// shared by the view matrix block; depends on nothing
package lavm_pkg;

    localparam int Q_W      = 32;            // Q16.16 word
    localparam int FRAC     = 16;
    localparam int AX_W     = 18;            // unit axis component, |v| <= 1.0
    localparam int QT_W     = AX_W - 1;      // quotient magnitude bits
    localparam int U_W      = 20;            // rounded up-axis component
    localparam int D_W      = Q_W + 1;       // eye minus target
    localparam int CR_W     = Q_W + AX_W;    // up cross forward
    localparam int NORM_W   = 30;            // scaled magnitude, top in [2^29, 2^30)
    localparam int NORM_MSB = NORM_W - 1;
    localparam int SQ_W     = 2 * NORM_W + 2;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int LEN_W    = SQ_STEPS;
    localparam int NUM_W    = LEN_W + FRAC + 1;
    localparam int PU_W     = 2 * AX_W;
    localparam int PD_W     = Q_W + U_W;
    localparam int ACC_W    = 56;
    localparam int RND_W    = ACC_W - FRAC;

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(1 << FRAC);

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic signed [ACC_W-1:0] HALF_UP = ACC_W'(1 << (FRAC - 1));
    localparam logic signed [ACC_W-1:0] HALF_DN = ACC_W'((1 << (FRAC - 1)) - 1);

    typedef struct packed {
        logic [2:0][2:0][Q_W-1:0] ax;   // [row][col], rows side, up, forward
        logic [2:0][Q_W-1:0]      tr;
        logic                     degen;
    } t_mat;

    typedef struct packed {
        logic [1:0]     idx;
        logic [Q_W-1:0] c0;
        logic [Q_W-1:0] c1;
        logic [Q_W-1:0] c2;
        logic [Q_W-1:0] c3;
        logic           degen;
        logic           last;
    } t_row;

    // round half away from zero, Q24.32 to Q24.16
    function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + (v[ACC_W-1] ? HALF_DN : HALF_UP);
        return t[ACC_W-1:FRAC];
    endfunction

    function automatic logic [Q_W-1:0] sat_q(input logic signed [RND_W-1:0] v);
        logic [Q_W-1:0] res;
        if ((&v[RND_W-1:Q_W-1]) || !(|v[RND_W-1:Q_W-1])) begin
            res = v[Q_W-1:0];
        end else if (v[RND_W-1]) begin
            res = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(Q_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: src/lavm_if.sv
// lavm_if: valid/ready channel interfaces for the point triple and the matrix rows
// depends on lavm_pkg
interface lavm_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [lavm_pkg::Q_W-1:0] eye_x;
    logic signed [lavm_pkg::Q_W-1:0] eye_y;
    logic signed [lavm_pkg::Q_W-1:0] eye_z;
    logic signed [lavm_pkg::Q_W-1:0] up_x;
    logic signed [lavm_pkg::Q_W-1:0] up_y;
    logic signed [lavm_pkg::Q_W-1:0] up_z;
    logic signed [lavm_pkg::Q_W-1:0] target_x;
    logic signed [lavm_pkg::Q_W-1:0] target_y;
    logic signed [lavm_pkg::Q_W-1:0] target_z;

    modport source (output valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
                    target_x, target_y, target_z, input ready);
    modport sink (input valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
                  target_x, target_y, target_z, output ready);
endinterface

interface lavm_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      row_index;
    logic signed [lavm_pkg::Q_W-1:0] col_zero;
    logic signed [lavm_pkg::Q_W-1:0] col_one;
    logic signed [lavm_pkg::Q_W-1:0] col_two;
    logic signed [lavm_pkg::Q_W-1:0] col_three;
    logic                            degenerate;
    logic                            last_row;

    modport source (output valid, row_index, col_zero, col_one, col_two, col_three,
                    degenerate, last_row, input ready);
    modport sink (input valid, row_index, col_zero, col_one, col_two, col_three,
                  degenerate, last_row, output ready);
endinterface

FILE: src/lavm_norm.sv
// lavm_norm: pipelined 3-vector normalizer, leading-one scale, one sqrt bit per
// stage, one quotient bit per stage; depends on lavm_pkg
module lavm_norm #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [IN_W-1:0]          i_c [3],
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic signed [lavm_pkg::AX_W-1:0] o_u [3],
    output logic                            o_ok,
    output logic [SIDE_W-1:0]               o_side
);
    import lavm_pkg::*;

    localparam int NCH   = (IN_W + 7) / 8;
    localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int POS_W = CH_W + 3;
    localparam int PAD_W = NCH * 8;
    localparam int NSTG  = 6 + SQ_STEPS + 1 + QT_W + 1;

    typedef struct packed {
        logic [SIDE_W-1:0]      side;
        logic [2:0]             neg;
        logic                   nz;
        logic [2:0][NORM_W-1:0] mm;
        logic [SQ_W-1:0]        n;
        logic [SQ_W-1:0]        r;
    } t_sq;

    typedef struct packed {
        logic [SIDE_W-1:0]     side;
        logic [2:0]            neg;
        logic                  nz;
        logic [LEN_W-1:0]      len;
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QT_W-1:0]  q;
    } t_dv;

    function automatic t_sq sq_step(input t_sq s, input int k);
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] rb;
        t_sq             o;
        b  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        rb = s.r + b;
        o  = s;
        if (s.n >= rb) begin
            o.n = s.n - rb;
            o.r = (s.r >> 1) + b;
        end else begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input int j);
        logic [NUM_W-1:0] d;
        t_dv              o;
        d = NUM_W'(s.len) << j;
        o = s;
        for (int i = 0; i < 3; i++) begin
            if (s.rem[i] >= d) begin
                o.rem[i]  = s.rem[i] - d;
                o.q[i][j] = 1'b1;
            end
        end
        return o;
    endfunction

    logic [NSTG-1:0] r_vld;

    // magnitudes and their or
    logic [2:0][IN_W-1:0] r_a_m,   n_a_m;
    logic [2:0]           r_a_neg, n_a_neg;
    logic [PAD_W-1:0]     r_a_or;
    logic [SIDE_W-1:0]    r_a_side;
    // coarse leading-one search over bytes
    logic [2:0][IN_W-1:0] r_b_m;
    logic [2:0]           r_b_neg;
    logic [PAD_W-1:0]     r_b_or;
    logic [CH_W-1:0]      r_b_hc,  n_b_hc;
    logic                 r_b_nz,  n_b_nz;
    logic [SIDE_W-1:0]    r_b_side;
    // fine search inside the byte
    logic [7:0]           c_byte;
    logic [2:0]           c_fb;
    logic [2:0][IN_W-1:0] r_c_m;
    logic [2:0]           r_c_neg;
    logic [POS_W-1:0]     r_c_pos;
    logic                 r_c_nz;
    logic [SIDE_W-1:0]    r_c_side;
    // scaled magnitudes
    logic [POS_W-1:0]       d_sh;
    logic [2:0][NORM_W-1:0] r_d_mm,  n_d_mm;
    logic [2:0]             r_d_neg;
    logic                   r_d_nz;
    logic [SIDE_W-1:0]      r_d_side;
    // squares
    logic [2:0][2*NORM_W-1:0] r_e_sq;
    logic [2:0][NORM_W-1:0]   r_e_mm;
    logic [2:0]               r_e_neg;
    logic                     r_e_nz;
    logic [SIDE_W-1:0]        r_e_side;

    t_sq                  r_sq [SQ_STEPS+1];
    t_sq                  n_sq0;
    t_dv                  r_dv [QT_W+1];
    t_dv                  n_dv0;

    logic signed [AX_W-1:0] r_o_u [3];
    logic                   r_o_ok;
    logic [SIDE_W-1:0]      r_o_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = i_c[i][IN_W-1];
            n_a_m[i]   = n_a_neg[i] ? IN_W'(-i_c[i]) : IN_W'(i_c[i]);
        end
    end

    always_comb begin
        n_b_hc = '0;
        n_b_nz = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            if (|r_a_or[i*8 +: 8]) begin
                n_b_hc = CH_W'(i);
                n_b_nz = 1'b1;
            end
        end
    end

    always_comb begin
        c_byte = r_b_or[{r_b_hc, 3'b000} +: 8];
        c_fb   = '0;
        for (int i = 0; i < 8; i++) begin
            if (c_byte[i]) c_fb = 3'(i);
        end
    end

    always_comb begin
        if (r_c_pos > POS_W'(NORM_MSB)) begin
            d_sh = r_c_pos - POS_W'(NORM_MSB);
            for (int i = 0; i < 3; i++) n_d_mm[i] = NORM_W'(r_c_m[i] >> d_sh);
        end else begin
            d_sh = POS_W'(NORM_MSB) - r_c_pos;
            for (int i = 0; i < 3; i++) n_d_mm[i] = NORM_W'(r_c_m[i] << d_sh);
        end
    end

    always_comb begin
        n_sq0.side = r_e_side;
        n_sq0.neg  = r_e_neg;
        n_sq0.nz   = r_e_nz;
        n_sq0.mm   = r_e_mm;
        n_sq0.n    = SQ_W'(r_e_sq[0]) + SQ_W'(r_e_sq[1]) + SQ_W'(r_e_sq[2]);
        n_sq0.r    = '0;
    end

    always_comb begin
        n_dv0.side = r_sq[SQ_STEPS].side;
        n_dv0.neg  = r_sq[SQ_STEPS].neg;
        n_dv0.nz   = r_sq[SQ_STEPS].nz;
        n_dv0.len  = r_sq[SQ_STEPS].r[LEN_W-1:0];
        n_dv0.q    = '0;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = (NUM_W'(r_sq[SQ_STEPS].mm[i]) << FRAC)
                         + NUM_W'(r_sq[SQ_STEPS].r[LEN_W-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_m    <= n_a_m;
            r_a_neg  <= n_a_neg;
            r_a_or   <= PAD_W'(n_a_m[0] | n_a_m[1] | n_a_m[2]);
            r_a_side <= i_side;

            r_b_m    <= r_a_m;
            r_b_neg  <= r_a_neg;
            r_b_or   <= r_a_or;
            r_b_hc   <= n_b_hc;
            r_b_nz   <= n_b_nz;
            r_b_side <= r_a_side;

            r_c_m    <= r_b_m;
            r_c_neg  <= r_b_neg;
            r_c_pos  <= {r_b_hc, c_fb};
            r_c_nz   <= r_b_nz;
            r_c_side <= r_b_side;

            r_d_mm   <= n_d_mm;
            r_d_neg  <= r_c_neg;
            r_d_nz   <= r_c_nz;
            r_d_side <= r_c_side;

            for (int i = 0; i < 3; i++) r_e_sq[i] <= r_d_mm[i] * r_d_mm[i];
            r_e_mm   <= r_d_mm;
            r_e_neg  <= r_d_neg;
            r_e_nz   <= r_d_nz;
            r_e_side <= r_d_side;

            r_sq[0] <= n_sq0;
            for (int k = 0; k < SQ_STEPS; k++) r_sq[k+1] <= sq_step(r_sq[k], k);

            r_dv[0] <= n_dv0;
            for (int k = 0; k < QT_W; k++) r_dv[k+1] <= dv_step(r_dv[k], QT_W - 1 - k);

            for (int i = 0; i < 3; i++) begin
                if (!r_dv[QT_W].nz) begin
                    r_o_u[i] <= '0;
                end else if (r_dv[QT_W].neg[i]) begin
                    r_o_u[i] <= -$signed({1'b0, r_dv[QT_W].q[i]});
                end else begin
                    r_o_u[i] <= $signed({1'b0, r_dv[QT_W].q[i]});
                end
            end
            r_o_ok   <= r_dv[QT_W].nz;
            r_o_side <= r_dv[QT_W].side;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_u     = r_o_u;
    assign o_ok    = r_o_ok;
    assign o_side  = r_o_side;

endmodule

FILE: src/lavm_post.sv
// lavm_post: up axis as forward cross side, then the three translation entries
// from eye dot axis, rounded and saturated; depends on lavm_pkg
module lavm_post (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [2:0][lavm_pkg::Q_W-1:0]    i_eye,
    input  logic signed [lavm_pkg::AX_W-1:0] i_f [3],
    input  logic signed [lavm_pkg::AX_W-1:0] i_s [3],
    input  logic                             i_degen,
    output logic                             o_valid,
    output lavm_pkg::t_mat                   o_mat
);
    import lavm_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;

    logic [2:0][Q_W-1:0]     r1_eye, r2_eye, r3_eye;
    logic signed [AX_W-1:0]  r1_f [3], r2_f [3], r3_f [3], r4_f [3], r5_f [3];
    logic signed [AX_W-1:0]  r1_s [3], r2_s [3], r3_s [3], r4_s [3], r5_s [3];
    logic                    r1_dg, r2_dg, r3_dg, r4_dg, r5_dg;
    logic signed [PU_W-1:0]  r1_pu [6];
    logic signed [PD_W-1:0]  r1_ps [3], r1_pf [3];
    logic signed [ACC_W-1:0] r2_ud [3];
    logic signed [ACC_W-1:0] r2_ns, r2_nf;
    logic signed [U_W-1:0]   r3_u [3], r4_u [3], r5_u [3];
    logic [Q_W-1:0]          r3_ts, r3_tf, r4_ts, r4_tf, r5_ts, r5_tf;
    logic signed [PD_W-1:0]  r4_pd [3];
    logic signed [ACC_W-1:0] r5_nu;
    t_mat                    r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products for the up cross and the side and forward dots
            r1_pu[0] <= i_f[1] * i_s[2];
            r1_pu[1] <= i_f[2] * i_s[1];
            r1_pu[2] <= i_f[2] * i_s[0];
            r1_pu[3] <= i_f[0] * i_s[2];
            r1_pu[4] <= i_f[0] * i_s[1];
            r1_pu[5] <= i_f[1] * i_s[0];
            for (int i = 0; i < 3; i++) begin
                r1_ps[i] <= $signed(i_eye[i]) * i_s[i];
                r1_pf[i] <= $signed(i_eye[i]) * i_f[i];
            end
            r1_eye <= i_eye;
            r1_f   <= i_f;
            r1_s   <= i_s;
            r1_dg  <= i_degen;

            for (int i = 0; i < 3; i++) begin
                r2_ud[i] <= ACC_W'(r1_pu[2*i]) - ACC_W'(r1_pu[2*i+1]);
            end
            r2_ns  <= -ACC_W'(r1_ps[0]) - ACC_W'(r1_ps[1]) - ACC_W'(r1_ps[2]);
            r2_nf  <= -ACC_W'(r1_pf[0]) - ACC_W'(r1_pf[1]) - ACC_W'(r1_pf[2]);
            r2_eye <= r1_eye;
            r2_f   <= r1_f;
            r2_s   <= r1_s;
            r2_dg  <= r1_dg;

            for (int i = 0; i < 3; i++) r3_u[i] <= U_W'(rnd_q16(r2_ud[i]));
            r3_ts  <= sat_q(rnd_q16(r2_ns));
            r3_tf  <= sat_q(rnd_q16(r2_nf));
            r3_eye <= r2_eye;
            r3_f   <= r2_f;
            r3_s   <= r2_s;
            r3_dg  <= r2_dg;

            for (int i = 0; i < 3; i++) r4_pd[i] <= $signed(r3_eye[i]) * r3_u[i];
            r4_u  <= r3_u;
            r4_ts <= r3_ts;
            r4_tf <= r3_tf;
            r4_f  <= r3_f;
            r4_s  <= r3_s;
            r4_dg <= r3_dg;

            r5_nu <= -ACC_W'(r4_pd[0]) - ACC_W'(r4_pd[1]) - ACC_W'(r4_pd[2]);
            r5_u  <= r4_u;
            r5_ts <= r4_ts;
            r5_tf <= r4_tf;
            r5_f  <= r4_f;
            r5_s  <= r4_s;
            r5_dg <= r4_dg;

            for (int i = 0; i < 3; i++) begin
                r_mat.ax[ROW_SIDE][i] <= Q_W'(r5_s[i]);
                r_mat.ax[ROW_UP][i]   <= Q_W'(r5_u[i]);
                r_mat.ax[ROW_FWD][i]  <= Q_W'(r5_f[i]);
            end
            r_mat.tr[ROW_SIDE] <= r5_ts;
            r_mat.tr[ROW_UP]   <= sat_q(rnd_q16(r5_nu));
            r_mat.tr[ROW_FWD]  <= r5_tf;
            r_mat.degen        <= r5_dg;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_mat   = r_mat;

endmodule

FILE: src/lavm_rows.sv
// lavm_rows: holds one finished matrix and sends it as four row transactions
// through a registered output; depends on lavm_pkg and lavm_out_if
module lavm_rows (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lavm_pkg::t_mat i_mat,
    output logic           o_ready,
    lavm_out_if.source     o_row
);
    import lavm_pkg::*;

    t_mat       r_mat;
    logic       r_have;
    logic [1:0] r_cnt;
    logic       r_ov;
    t_row       r_row, n_row;
    logic       load_out;

    assign load_out = r_have && (!r_ov || o_row.ready);
    // the buffer frees up as its last row moves to the output register
    assign o_ready  = !r_have || (load_out && r_cnt == ROW_LAST);

    always_comb begin
        n_row.idx   = r_cnt;
        n_row.degen = r_mat.degen;
        n_row.last  = (r_cnt == ROW_LAST);
        if (r_cnt == ROW_LAST) begin
            n_row.c0 = '0;
            n_row.c1 = '0;
            n_row.c2 = '0;
            n_row.c3 = ONE_Q16;
        end else begin
            n_row.c0 = r_mat.ax[r_cnt][0];
            n_row.c1 = r_mat.ax[r_cnt][1];
            n_row.c2 = r_mat.ax[r_cnt][2];
            n_row.c3 = r_mat.tr[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cnt  <= ROW_SIDE;
            r_ov   <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_row.ready) begin
                r_ov <= 1'b0;
            end
            // a matrix enters an empty buffer or as its last row leaves, so cnt is 0 anyway
            if (i_valid && o_ready) begin
                r_have <= 1'b1;
                r_cnt  <= ROW_SIDE;
            end else if (load_out) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == ROW_LAST) r_have <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_row <= n_row;
        if (i_valid && o_ready) r_mat <= i_mat;
    end

    assign o_row.valid      = r_ov;
    assign o_row.row_index  = r_row.idx;
    assign o_row.col_zero   = r_row.c0;
    assign o_row.col_one    = r_row.c1;
    assign o_row.col_two    = r_row.c2;
    assign o_row.col_three  = r_row.c3;
    assign o_row.degenerate = r_row.degen;
    assign o_row.last_row   = r_row.last;

endmodule

FILE: src/look_at_view_matrix.sv
// look_at_view_matrix: view matrix from eye, up and target, sent as four rows
// the first row is followed by the other three rows one per cycle while the receiver
// is ready; an item may enter every cycle into the pipe while the pipe is not stalled;
// the item rate is bounded by the single row output channel, four rows per item
// reset: synchronous active low, clears valid bits and the row sequencer only
// depends on lavm_pkg, lavm_if, lavm_norm, lavm_post, lavm_rows
module look_at_view_matrix (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lavm_in_if.sink    i_pt,
    lavm_out_if.source o_row
);
    import lavm_pkg::*;

    localparam int SIDE1_W = 6 * Q_W;
    localparam int SIDE2_W = 3 * Q_W + 3 * AX_W + 1;

    logic en;
    logic buf_ready;
    logic post_valid;
    t_mat post_mat;

    // front: difference of eye and target
    logic                  r_v0;
    logic signed [D_W-1:0] r_d [3];
    logic [2:0][Q_W-1:0]   r_p0_eye, r_p0_up;

    logic                   n1_valid, n1_ok;
    logic signed [AX_W-1:0] n1_f [3];
    logic [SIDE1_W-1:0]     n1_side;
    logic [2:0][Q_W-1:0]    n1_eye, n1_up;

    // cross of up and forward
    logic                    r_v1, r_v2;
    logic signed [CR_W-1:0]  r_x_p [6];
    logic signed [CR_W-1:0]  r_x_cr [3];
    logic [2:0][Q_W-1:0]     r_x1_eye, r_x2_eye;
    logic [2:0][AX_W-1:0]    r_x1_f, r_x2_f;
    logic                    r_x1_ok, r_x2_ok;

    logic                   n2_valid, n2_ok;
    logic signed [AX_W-1:0] n2_s [3];
    logic [SIDE2_W-1:0]     n2_side;
    logic [2:0][Q_W-1:0]    n2_eye;
    logic [2:0][AX_W-1:0]   n2_fp;
    logic signed [AX_W-1:0] n2_f [3];
    logic                   n2_okf;

    assign en        = !post_valid || buf_ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_pt.valid;
            r_v1 <= n1_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]   <= D_W'(i_pt.eye_x) - D_W'(i_pt.target_x);
            r_d[1]   <= D_W'(i_pt.eye_y) - D_W'(i_pt.target_y);
            r_d[2]   <= D_W'(i_pt.eye_z) - D_W'(i_pt.target_z);
            r_p0_eye <= {i_pt.eye_z, i_pt.eye_y, i_pt.eye_x};
            r_p0_up  <= {i_pt.up_z, i_pt.up_y, i_pt.up_x};

            r_x_p[0] <= $signed(n1_up[1]) * n1_f[2];
            r_x_p[1] <= $signed(n1_up[2]) * n1_f[1];
            r_x_p[2] <= $signed(n1_up[2]) * n1_f[0];
            r_x_p[3] <= $signed(n1_up[0]) * n1_f[2];
            r_x_p[4] <= $signed(n1_up[0]) * n1_f[1];
            r_x_p[5] <= $signed(n1_up[1]) * n1_f[0];
            r_x1_eye <= n1_eye;
            for (int i = 0; i < 3; i++) r_x1_f[i] <= n1_f[i];
            r_x1_ok  <= n1_ok;

            for (int i = 0; i < 3; i++) r_x_cr[i] <= r_x_p[2*i] - r_x_p[2*i+1];
            r_x2_eye <= r_x1_eye;
            r_x2_f   <= r_x1_f;
            r_x2_ok  <= r_x1_ok;
        end
    end

    lavm_norm #(
        .IN_W   (D_W),
        .SIDE_W (SIDE1_W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_c     (r_d),
        .i_side  ({r_p0_eye, r_p0_up}),
        .o_valid (n1_valid),
        .o_u     (n1_f),
        .o_ok    (n1_ok),
        .o_side  (n1_side)
    );

    assign {n1_eye, n1_up} = n1_side;

    lavm_norm #(
        .IN_W   (CR_W),
        .SIDE_W (SIDE2_W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_c     (r_x_cr),
        .i_side  ({r_x2_eye, r_x2_f, r_x2_ok}),
        .o_valid (n2_valid),
        .o_u     (n2_s),
        .o_ok    (n2_ok),
        .o_side  (n2_side)
    );

    assign {n2_eye, n2_fp, n2_okf} = n2_side;

    always_comb begin
        for (int i = 0; i < 3; i++) n2_f[i] = $signed(n2_fp[i]);
    end

    lavm_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n2_valid),
        .i_eye   (n2_eye),
        .i_f     (n2_f),
        .i_s     (n2_s),
        .i_degen (!(n2_okf && n2_ok)),
        .o_valid (post_valid),
        .o_mat   (post_mat)
    );

    lavm_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (post_valid),
        .i_mat   (post_mat),
        .o_ready (buf_ready),
        .o_row   (o_row)
    );

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for look_at_view_matrix, drives point triples and checks
// every matrix row against a bit-exact fixed-point predictor
// depends on lavm_pkg, lavm_if and the look_at_view_matrix rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lavm_pkg::*;

    localparam int N_RANDOM  = 280;
    localparam int CALM_FROM = 240;
    localparam int HOLD_AT   = 100;
    localparam int HOLD_LEN  = 400;
    localparam int LIMIT     = 200000;

    typedef struct {
        longint eye [3];
        longint up  [3];
        longint tgt [3];
    } t_point;

    class view_board;
        t_row rows_due [$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // scale so the top magnitude sits in [2^29, 2^30), then divide by the length
        function bit unit(input longint c [3], output longint o [3]);
            longint unsigned m [3];
            longint unsigned top, sum, len, q;
            int up_sh, dn_sh;
            top = 0; sum = 0; up_sh = 0; dn_sh = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = mag(c[i]);
                if (m[i] > top) top = m[i];
            end
            if (top == 0) begin
                for (int i = 0; i < 3; i++) o[i] = 0;
                return 0;
            end
            while (top >= (64'd1 << 30)) begin top = top >> 1; dn_sh++; end
            while (top < (64'd1 << 29)) begin top = top << 1; up_sh++; end
            for (int i = 0; i < 3; i++) begin
                m[i] = dn_sh != 0 ? (m[i] >> dn_sh) : (m[i] << up_sh);
                sum = sum + m[i] * m[i];
            end
            len = root(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 16) + (len >> 1)) / len;
                o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function longint to_q16(longint v);
            longint unsigned r;
            r = (mag(v) + 32768) >> 16;
            return v < 0 ? -longint'(r) : longint'(r);
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note(t_point p);
            longint d [3], f [3], cr [3], s [3], u [3], ax [3][3], tr [3];
            bit ok_f, ok_s;
            t_row r;
            for (int i = 0; i < 3; i++) d[i] = p.eye[i] - p.tgt[i];
            ok_f = unit(d, f);
            cr[0] = p.up[1] * f[2] - p.up[2] * f[1];
            cr[1] = p.up[2] * f[0] - p.up[0] * f[2];
            cr[2] = p.up[0] * f[1] - p.up[1] * f[0];
            ok_s = unit(cr, s);
            u[0] = to_q16(f[1] * s[2] - f[2] * s[1]);
            u[1] = to_q16(f[2] * s[0] - f[0] * s[2]);
            u[2] = to_q16(f[0] * s[1] - f[1] * s[0]);
            ax[0] = s; ax[1] = u; ax[2] = f;
            for (int k = 0; k < 3; k++) begin
                tr[k] = sat32(-to_q16(p.eye[0] * ax[k][0] + p.eye[1] * ax[k][1]
                                      + p.eye[2] * ax[k][2]));
                r.idx   = k == 0 ? ROW_SIDE : (k == 1 ? ROW_UP : ROW_FWD);
                r.c0    = ax[k][0][31:0];
                r.c1    = ax[k][1][31:0];
                r.c2    = ax[k][2][31:0];
                r.c3    = tr[k][31:0];
                r.degen = !(ok_f && ok_s);
                r.last  = 1'b0;
                rows_due.push_back(r);
            end
            r.idx = ROW_LAST;
            r.c0 = '0; r.c1 = '0; r.c2 = '0;
            r.c3 = ONE_Q16;
            r.last = 1'b1;
            rows_due.push_back(r);
        endfunction

        function void check(t_row got);
            t_row want;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row %p", $realtime, got);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got !== want) begin
                $display("%0t: row mismatch expected %p actual %p", $realtime, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    lavm_in_if  pt ();
    lavm_out_if rw ();

    look_at_view_matrix i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt),
        .o_row   (rw)
    );

    view_board board;
    int  sent;
    int  rows_seen;
    int  cycles;
    bit  calm;
    bit  held;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output transaction check
    always @(posedge clk) begin
        t_row got;
        if (rst_n && rw.valid && rw.ready) begin
            got.idx   = rw.row_index;
            got.c0    = rw.col_zero;
            got.c1    = rw.col_one;
            got.c2    = rw.col_two;
            got.c3    = rw.col_three;
            got.degen = rw.degenerate;
            got.last  = rw.last_row;
            board.check(got);
            rows_seen++;
        end
    end

    // receiver: random stall bursts plus one long hold-off to back up the pipe
    initial begin
        rw.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && rows_seen >= HOLD_AT) begin
                held = 1;
                rw.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            if (!calm && $urandom_range(0, 4) == 0) begin
                rw.ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
                if (rw.ready == 1'b0) @(negedge clk);
            end
            rw.ready = 1'b1;
        end
    end

    task automatic send_point(t_point p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            pt.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        pt.valid    = 1'b1;
        pt.eye_x    = p.eye[0][31:0];
        pt.eye_y    = p.eye[1][31:0];
        pt.eye_z    = p.eye[2][31:0];
        pt.up_x     = p.up[0][31:0];
        pt.up_y     = p.up[1][31:0];
        pt.up_z     = p.up[2][31:0];
        pt.target_x = p.tgt[0][31:0];
        pt.target_y = p.tgt[1][31:0];
        pt.target_z = p.tgt[2][31:0];
        do @(posedge clk); while (!pt.ready);
        board.note(p);
        sent++;
        if (sent >= CALM_FROM) calm = 1;
        @(negedge clk);
    endtask

    function automatic longint word(logic [31:0] w);
        return longint'($signed(w));
    endfunction

    function automatic t_point make_point(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                                          logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                                          logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        t_point p;
        p.eye[0] = word(ex); p.eye[1] = word(ey); p.eye[2] = word(ez);
        p.up[0]  = word(ux); p.up[1]  = word(uy); p.up[2]  = word(uz);
        p.tgt[0] = word(tx); p.tgt[1] = word(ty); p.tgt[2] = word(tz);
        return p;
    endfunction

    function automatic logic [31:0] rnd_word(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
            default: return 32'($signed($urandom_range(0, 2 * 4096)) - 4096);
        endcase
    endfunction

    function automatic t_point random_point();
        t_point p;
        int kind, sel, axis;
        kind = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            p.eye[i] = word(rnd_word(kind));
            p.up[i]  = word(rnd_word(kind));
            p.tgt[i] = word(rnd_word(kind));
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            p.tgt = p.eye;                      // eye on target
        end else if (sel == 1) begin
            // forward and up on one axis, so their cross is exactly zero
            axis = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                p.tgt[i] = p.eye[i];
                p.up[i]  = 0;
            end
            p.tgt[axis] = p.eye[axis] - longint'($urandom_range(1, 65535))
                          + longint'($urandom_range(0, 65535));
            // keep the target a valid 32-bit word, as the port carries it
            p.tgt[axis] = word(p.tgt[axis][31:0]);
            if ($urandom_range(0, 3) != 0) p.up[axis] = word(rnd_word(kind));
        end
        return p;
    endfunction

    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONE  = 32'h00010000;
    localparam logic [31:0] MONE = 32'hffff0000;

    initial begin
        board = new();
        sent = 0; rows_seen = 0; cycles = 0; calm = 0; held = 0;
        rst_n = 1'b0;
        pt.valid = 1'b0;
        pt.eye_x = '0; pt.eye_y = '0; pt.eye_z = '0;
        pt.up_x = '0; pt.up_y = '0; pt.up_z = '0;
        pt.target_x = '0; pt.target_y = '0; pt.target_z = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        send_point(make_point(0, 0, ONE, 0, ONE, 0, 0, 0, 0));
        send_point(make_point(ONE, ONE, ONE, 0, ONE, 0, 0, 0, 0));
        send_point(make_point(ONE, 2, 3, 0, ONE, 0, ONE, 2, 3));          // eye on target
        send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_point(make_point(0, ONE, 0, 0, ONE, 0, 0, 0, 0));            // up along forward
        send_point(make_point(0, 0, ONE, 0, 0, 0, 0, 0, 0));              // zero up
        send_point(make_point(0, MONE, 0, 0, ONE, 0, 0, 0, 0));
        send_point(make_point(MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV, MINV, MINV));
        send_point(make_point(MINV, MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV));
        send_point(make_point(MAXV, MINV, MAXV, 0, ONE, 0, MINV, MAXV, MINV));
        send_point(make_point(MAXV, MAXV, MAXV, 0, MAXV, 1, 0, 0, 0));    // translation saturates
        send_point(make_point(MINV, MINV, MINV, 0, MINV, 1, 0, 0, 0));
        send_point(make_point(1, 0, 0, 0, 1, 0, 0, 0, 0));
        send_point(make_point(1, 1, 1, 1, 0, 0, 0, 0, 0));
        send_point(make_point(32'hffffffff, 0, 0, 0, 0, MAXV, 0, 0, 0));
        send_point(make_point(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h55555555,
                              32'haaaaaaaa, 32'h33333333, 32'hcccccccc, 32'h0f0f0f0f,
                              32'hf0f0f0f0));
        send_point(make_point(ONE, 0, 0, MINV, MINV, MINV, 0, ONE, 0));

        for (int n = 0; n < N_RANDOM; n++) send_point(random_point());
        pt.valid = 1'b0;

        while (board.rows_due.size() != 0) @(posedge clk);
        repeat (140) @(posedge clk);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: files.f
src/lavm_pkg.sv
src/lavm_if.sv
src/lavm_norm.sv
src/lavm_post.sv
src/lavm_rows.sv
src/look_at_view_matrix.sv
bench/tb.sv
